/* hw/rtl/mae_pkg.sv */
// ----------------------------------------------------------------------------
// mae_pkg
// Operation codes, state and phase codes and fixed field widths for the 4x4 matrix engine.
// ----------------------------------------------------------------------------
package mae_pkg;

   localparam int FUNC_W  = 4;
   localparam int INDEX_W = 4;
   localparam int FIELD_W = 32;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_WR_A     = 4'd0;
   localparam logic [FUNC_W-1:0] FN_WR_B     = 4'd1;
   localparam logic [FUNC_W-1:0] FN_RD_A     = 4'd2;
   localparam logic [FUNC_W-1:0] FN_ADD      = 4'd3;
   localparam logic [FUNC_W-1:0] FN_SUB      = 4'd4;
   localparam logic [FUNC_W-1:0] FN_SCALE    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_ADD_SCL  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_MATMUL   = 4'd7;
   localparam logic [FUNC_W-1:0] FN_VECMAT   = 4'd8;
   localparam logic [FUNC_W-1:0] FN_MATVEC   = 4'd9;

   // range of codes that do nothing
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd10;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // phases of one term
   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ACC  = 2'd2;

   typedef logic signed [FIELD_W-1:0] field_type;

endpackage

/* hw/rtl/matrix4_arith_engine.sv */
// ----------------------------------------------------------------------------
// matrix4_arith_engine
// 4x4 fixed-point matrix unit: element access, add/sub/scale, matrix product
// and vector transforms on an accumulator matrix A and operand matrix B.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one word per operation, selected by req_func.
//    req_ready is high whenever the sequencer is idle.
//  - Response channel (rsp_*): exactly one word per request, in order.
//    Unused fields are zero; rsp_saturated flags any clamp in the operation.
//  - A and B live in two 16-entry memories with a registered read.
//    Work is done as terms of read / multiply / accumulate on a single
//    shared multiplier:
//      write, read, unused codes : 1 term
//      add, sub, scale, add-scaled, vector transforms : 16 terms
//      matrix product : 64 terms
//    rsp_valid rises in the same cycle that req_ready returns, so a new
//    request is taken only once the last response is in the output register.
//  - The matrix product runs column by column; each column of A is captured
//    into registers on its first row pass, so A is overwritten in place.
//  - The output register parts the channels: a new request is taken while
//    the last response still waits. If the receiver stalls, a finished
//    operation holds in the last state until the output register frees.
//  - Reset (synchronous, active high) clears both matrices through per-entry
//    valid bits, so the block is usable in the cycle after reset.
// ----------------------------------------------------------------------------
module matrix4_arith_engine #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mae_pkg::FUNC_W-1:0]     req_func,
   input  logic [mae_pkg::INDEX_W-1:0]    req_elem_index,
   input  logic signed [mae_pkg::FIELD_W-1:0] req_elem_value,
   input  logic signed [mae_pkg::FIELD_W-1:0] req_scale,
   input  logic signed [mae_pkg::FIELD_W-1:0] req_vec_x,
   input  logic signed [mae_pkg::FIELD_W-1:0] req_vec_y,
   input  logic signed [mae_pkg::FIELD_W-1:0] req_vec_z,
   input  logic signed [mae_pkg::FIELD_W-1:0] req_vec_w,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [mae_pkg::FIELD_W-1:0] rsp_read_value,
   output logic signed [mae_pkg::FIELD_W-1:0] rsp_res_x,
   output logic signed [mae_pkg::FIELD_W-1:0] rsp_res_y,
   output logic signed [mae_pkg::FIELD_W-1:0] rsp_res_z,
   output logic signed [mae_pkg::FIELD_W-1:0] rsp_res_w,
   output logic                           rsp_saturated
);

   localparam int FW    = mae_pkg::FIELD_W;
   localparam int MY_W  = (WORD_BITS > FW) ? WORD_BITS : FW;  // multiplier y width
   localparam int P_W   = WORD_BITS + MY_W;                   // full product
   localparam int ACC_W = P_W + 3;                            // four products + margin

   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN =
      {{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

   // ---------------- control and payload registers ----------------
   logic [1:0] state_ff, state_in;
   logic [1:0] ph_ff, ph_in;
   logic [5:0] t_ff, t_in;          // term counter: [5:4] col, [3:2] row, [1:0] k
   logic [5:0] last_ff, last_in;
   logic [mae_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [mae_pkg::INDEX_W-1:0] idx_ff, idx_in;
   mae_pkg::field_type ev_ff, ev_in, s_ff, s_in;
   mae_pkg::field_type v_ff [4];
   mae_pkg::field_type v_in [4];

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [WORD_BITS-1:0] ah_ff, ah_in, bh_ff, bh_in;
   logic signed [WORD_BITS-1:0] col_ff [4];
   logic signed [WORD_BITS-1:0] col_in [4];

   mae_pkg::field_type rd_ff, rd_in;
   mae_pkg::field_type r_ff [4];
   mae_pkg::field_type r_in [4];
   logic sat_ff, sat_in;

   logic rsp_valid_ff, rsp_valid_in;
   mae_pkg::field_type rsp_rd_ff, rsp_rd_in;
   mae_pkg::field_type rsp_r_ff [4];
   mae_pkg::field_type rsp_r_in [4];
   logic rsp_sat_ff, rsp_sat_in;

   // ---------------- matrix memories ----------------
   logic [WORD_BITS-1:0] mem_a [16];
   logic [WORD_BITS-1:0] mem_b [16];
   logic [15:0] a_vld_ff, b_vld_ff;
   logic [WORD_BITS-1:0] a_q_ff, b_q_ff;
   logic a_qv_ff, b_qv_ff;
   logic [3:0] a_addr, b_addr, a_waddr;
   logic a_we, b_we;
   logic signed [WORD_BITS-1:0] a_rd, b_rd, sat_v;

   // ---------------- term decode ----------------
   logic [1:0] kk, row, coln;
   logic is_dot, grp_first, grp_end;
   logic signed [WORD_BITS-1:0] mx;
   logic signed [MY_W-1:0] my;
   logic signed [P_W-1:0] prod_full;
   logic signed [ACC_W-1:0] addend, acc_base;
   logic clamp;

   assign kk   = t_ff[1:0];
   assign row  = t_ff[3:2];
   assign coln = t_ff[5:4];

   assign a_rd = a_qv_ff ? $signed(a_q_ff) : '0;
   assign b_rd = b_qv_ff ? $signed(b_q_ff) : '0;

   assign is_dot = (func_ff == mae_pkg::FN_MATMUL) || (func_ff == mae_pkg::FN_VECMAT) ||
                   (func_ff == mae_pkg::FN_MATVEC);
   assign grp_first = is_dot ? (kk == 2'd0) : 1'b1;
   assign grp_end   = is_dot ? (kk == 2'd3) : 1'b1;

   // read addresses and multiplier operands
   always_comb begin
      a_addr = t_ff[3:0];
      b_addr = t_ff[3:0];
      a_waddr = t_ff[3:0];
      mx = a_rd;
      my = MY_W'(s_ff);
      unique case (func_ff)
         mae_pkg::FN_WR_A, mae_pkg::FN_RD_A: begin
            a_addr  = idx_ff;
            a_waddr = idx_ff;
         end
         mae_pkg::FN_WR_B: begin
            b_addr = idx_ff;
         end
         mae_pkg::FN_ADD_SCL: begin
            mx = b_rd;
         end
         mae_pkg::FN_MATMUL: begin
            a_addr  = {kk, coln};
            b_addr  = {row, kk};
            a_waddr = {row, coln};
            mx = b_rd;
            my = (row == 2'd0) ? MY_W'(a_rd) : MY_W'(col_ff[kk]);
         end
         mae_pkg::FN_VECMAT: begin
            a_addr = {kk, row};
            my = MY_W'(v_ff[kk]);
         end
         mae_pkg::FN_MATVEC: begin
            a_addr = {row, kk};
            my = MY_W'(v_ff[kk]);
         end
         default: begin
         end
      endcase
   end

   assign prod_full = P_W'(mx) * P_W'(my);

   // accumulate term and saturate
   always_comb begin
      unique case (func_ff)
         mae_pkg::FN_WR_A, mae_pkg::FN_WR_B: addend = ACC_W'(ev_ff);
         mae_pkg::FN_ADD:     addend = ACC_W'(ah_ff) + ACC_W'(bh_ff);
         mae_pkg::FN_SUB:     addend = ACC_W'(ah_ff) - ACC_W'(bh_ff);
         mae_pkg::FN_SCALE:   addend = prod_ff;
         mae_pkg::FN_ADD_SCL: addend = ACC_W'(ah_ff) + prod_ff;
         mae_pkg::FN_MATMUL, mae_pkg::FN_VECMAT, mae_pkg::FN_MATVEC: addend = prod_ff;
         default:             addend = '0;
      endcase
      acc_base = grp_first ? '0 : acc_ff;
   end

   assign acc_in = acc_base + addend;

   always_comb begin
      clamp = 1'b0;
      sat_v = acc_in[WORD_BITS-1:0];
      if (acc_in > SAT_MAX) begin
         clamp = 1'b1;
         sat_v = SAT_MAX[WORD_BITS-1:0];
      end else if (acc_in < SAT_MIN) begin
         clamp = 1'b1;
         sat_v = SAT_MIN[WORD_BITS-1:0];
      end
   end

   // memory write enables, end of a group only
   always_comb begin
      a_we = 1'b0;
      b_we = 1'b0;
      if (state_ff == mae_pkg::ST_RUN && ph_ff == mae_pkg::PH_ACC && grp_end) begin
         unique case (func_ff)
            mae_pkg::FN_WR_A, mae_pkg::FN_ADD, mae_pkg::FN_SUB, mae_pkg::FN_SCALE,
            mae_pkg::FN_ADD_SCL, mae_pkg::FN_MATMUL: a_we = 1'b1;
            mae_pkg::FN_WR_B: b_we = 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         mem_a[a_waddr] <= sat_v;
      end
      if (b_we) begin
         mem_b[b_addr] <= sat_v;
      end
      a_q_ff <= mem_a[a_addr];
      b_q_ff <= mem_b[b_addr];
      a_qv_ff <= a_vld_ff[a_addr];
      b_qv_ff <= b_vld_ff[b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (a_we) begin
            a_vld_ff[a_waddr] <= 1'b1;
         end
         if (b_we) begin
            b_vld_ff[b_addr] <= 1'b1;
         end
      end
   end

   // ---------------- sequencer ----------------
   logic rsp_load;

   assign req_ready = (state_ff == mae_pkg::ST_IDLE);
   assign rsp_load  = (state_ff == mae_pkg::ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      t_in     = t_ff;
      last_in  = last_ff;
      func_in  = func_ff;
      idx_in   = idx_ff;
      ev_in    = ev_ff;
      s_in     = s_ff;
      v_in     = v_ff;
      prod_in  = prod_ff;
      ah_in    = ah_ff;
      bh_in    = bh_ff;
      col_in   = col_ff;
      rd_in    = rd_ff;
      r_in     = r_ff;
      sat_in   = sat_ff;

      unique case (state_ff)
         mae_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mae_pkg::ST_RUN;
               ph_in    = mae_pkg::PH_ADDR;
               t_in     = '0;
               func_in  = req_func;
               idx_in   = req_elem_index;
               ev_in    = req_elem_value;
               s_in     = req_scale;
               v_in[0]  = req_vec_x;
               v_in[1]  = req_vec_y;
               v_in[2]  = req_vec_z;
               v_in[3]  = req_vec_w;
               rd_in    = '0;
               for (int n = 0; n < 4; n++) begin
                  r_in[n] = '0;
               end
               sat_in   = 1'b0;
               unique case (req_func)
                  mae_pkg::FN_ADD, mae_pkg::FN_SUB, mae_pkg::FN_SCALE,
                  mae_pkg::FN_ADD_SCL, mae_pkg::FN_VECMAT, mae_pkg::FN_MATVEC:
                     last_in = 6'd15;
                  mae_pkg::FN_MATMUL: last_in = 6'd63;
                  default:            last_in = 6'd0;
               endcase
            end
         end
         mae_pkg::ST_RUN: begin
            unique case (ph_ff)
               mae_pkg::PH_ADDR: begin
                  ph_in = mae_pkg::PH_MUL;
               end
               mae_pkg::PH_MUL: begin
                  ph_in   = mae_pkg::PH_ACC;
                  ah_in   = a_rd;
                  bh_in   = b_rd;
                  prod_in = ACC_W'(prod_full >>> FRAC_BITS);
                  if (func_ff == mae_pkg::FN_MATMUL && row == 2'd0) begin
                     col_in[kk] = a_rd;
                  end
               end
               mae_pkg::PH_ACC: begin
                  if (grp_end) begin
                     sat_in = sat_ff | clamp;
                     if (func_ff == mae_pkg::FN_RD_A) begin
                        rd_in = FW'(a_rd);
                     end
                     if (func_ff == mae_pkg::FN_VECMAT || func_ff == mae_pkg::FN_MATVEC) begin
                        r_in[row] = FW'(sat_v);
                     end
                  end
                  ph_in = mae_pkg::PH_ADDR;
                  if (t_ff == last_ff) begin
                     state_in = mae_pkg::ST_FIN;
                  end else begin
                     t_in = t_ff + 6'd1;
                  end
               end
               default: begin
                  ph_in = mae_pkg::PH_ADDR;
               end
            endcase
         end
         mae_pkg::ST_FIN: begin
            if (rsp_load) begin
               state_in = mae_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mae_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_rd_in    = rd_ff;
         rsp_r_in     = r_ff;
         rsp_sat_in   = sat_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mae_pkg::ST_IDLE;
         ph_ff        <= mae_pkg::PH_ADDR;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      func_ff    <= func_in;
      idx_ff     <= idx_in;
      ev_ff      <= ev_in;
      s_ff       <= s_in;
      v_ff       <= v_in;
      // partial sum advances only in the accumulate phase
      if (state_ff == mae_pkg::ST_RUN && ph_ff == mae_pkg::PH_ACC) begin
         acc_ff  <= acc_in;
      end
      prod_ff    <= prod_in;
      ah_ff      <= ah_in;
      bh_ff      <= bh_in;
      col_ff     <= col_in;
      rd_ff      <= rd_in;
      r_ff       <= r_in;
      sat_ff     <= sat_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_r_ff   <= rsp_r_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_res_x      = rsp_r_ff[0];
   assign rsp_res_y      = rsp_r_ff[1];
   assign rsp_res_z      = rsp_r_ff[2];
   assign rsp_res_w      = rsp_r_ff[3];
   assign rsp_saturated  = rsp_sat_ff;

endmodule

/* hw/rtl/mae_checker.sv */
// ----------------------------------------------------------------------------
// mae_checker
// Port-level checks for the matrix engine: ordering of request and response, quiet after reset, stalled response hold.
// ----------------------------------------------------------------------------
module mae_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mae_pkg::FIELD_W-1:0]  rsp_read_value
);

   logic [2:0] pend_ff, pend_in;
   logic req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 3'd1;
      end else if (!req_fire && rsp_fire) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a response only for a request taken earlier
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 3'd0))
      else $error("response with no request outstanding");

   // at most one in work and one in the output register
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd2)
      else $error("more than two words outstanding");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("stalled response dropped or changed");

endmodule

bind matrix4_arith_engine mae_checker u_mae_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value)
);

/* tb/sv/matrix4_arith_engine_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix4_arith_engine_chk
// Watches both channels, keeps its own copy of A and B and compares every
// response word field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module matrix4_arith_engine_chk (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [mae_pkg::FUNC_W-1:0]          req_func,
   input  logic [mae_pkg::INDEX_W-1:0]         req_elem_index,
   input  logic signed [mae_pkg::FIELD_W-1:0]  req_elem_value,
   input  logic signed [mae_pkg::FIELD_W-1:0]  req_scale,
   input  logic signed [mae_pkg::FIELD_W-1:0]  req_vec_x,
   input  logic signed [mae_pkg::FIELD_W-1:0]  req_vec_y,
   input  logic signed [mae_pkg::FIELD_W-1:0]  req_vec_z,
   input  logic signed [mae_pkg::FIELD_W-1:0]  req_vec_w,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [mae_pkg::FIELD_W-1:0]  rsp_read_value,
   input  logic signed [mae_pkg::FIELD_W-1:0]  rsp_res_x,
   input  logic signed [mae_pkg::FIELD_W-1:0]  rsp_res_y,
   input  logic signed [mae_pkg::FIELD_W-1:0]  rsp_res_z,
   input  logic signed [mae_pkg::FIELD_W-1:0]  rsp_res_w,
   input  logic                                rsp_saturated,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int FRAC = 16;

   typedef struct {
      logic signed [31:0] rd;
      logic signed [31:0] r [4];
      logic               sat;
   } word_type;

   logic signed [31:0] mat_a [16];
   logic signed [31:0] mat_b [16];
   word_type           expected_words [$];

   assign pending = expected_words.size();

   function automatic logic signed [95:0] fx_mul(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [95:0] p;
      p = 96'(x) * 96'(y);
      return p >>> FRAC;
   endfunction

   function automatic logic signed [31:0] clamp(logic signed [95:0] v, ref logic sat);
      if (v > 96'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -96'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   task automatic predict_word(output word_type w);
      logic signed [31:0] vin [4];
      logic signed [31:0] nxt [16];
      logic signed [95:0] acc;
      int e;
      w.rd = '0;
      w.sat = 1'b0;
      for (int i = 0; i < 4; i++) w.r[i] = '0;
      vin[0] = req_vec_x; vin[1] = req_vec_y; vin[2] = req_vec_z; vin[3] = req_vec_w;
      case (req_func)
         mae_pkg::FN_WR_A: mat_a[req_elem_index] = req_elem_value;
         mae_pkg::FN_WR_B: mat_b[req_elem_index] = req_elem_value;
         mae_pkg::FN_RD_A: w.rd = mat_a[req_elem_index];
         mae_pkg::FN_ADD, mae_pkg::FN_SUB, mae_pkg::FN_SCALE, mae_pkg::FN_ADD_SCL: begin
            for (int i = 0; i < 16; i++) begin
               if (req_func == mae_pkg::FN_SCALE) acc = fx_mul(mat_a[i], req_scale);
               else if (req_func == mae_pkg::FN_ADD) acc = 96'(mat_a[i]) + 96'(mat_b[i]);
               else if (req_func == mae_pkg::FN_SUB) acc = 96'(mat_a[i]) - 96'(mat_b[i]);
               else acc = 96'(mat_a[i]) + fx_mul(mat_b[i], req_scale);
               mat_a[i] = clamp(acc, w.sat);
            end
         end
         mae_pkg::FN_MATMUL: begin
            // row-major index: new A[i][j] = sum_k A[k][j] * B[i][k]
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 4; j++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++)
                     acc += fx_mul(mat_a[k*4+j], mat_b[i*4+k]);
                  nxt[i*4+j] = clamp(acc, w.sat);
               end
            mat_a = nxt;
         end
         mae_pkg::FN_VECMAT, mae_pkg::FN_MATVEC: begin
            for (int i = 0; i < 4; i++) begin
               acc = '0;
               for (int k = 0; k < 4; k++) begin
                  e = (req_func == mae_pkg::FN_VECMAT) ? k*4+i : i*4+k;
                  acc += fx_mul(vin[k], mat_a[e]);
               end
               w.r[i] = clamp(acc, w.sat);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic signed [31:0] got, logic signed [31:0] exp);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, exp);
      fail_count++;
   endtask

   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
         end
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(w);
            expected_words.push_back(w);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_read_value, '0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_read_value !== w.rd) report_mismatch("read_value", rsp_read_value, w.rd);
               if (rsp_res_x !== w.r[0]) report_mismatch("res_x", rsp_res_x, w.r[0]);
               if (rsp_res_y !== w.r[1]) report_mismatch("res_y", rsp_res_y, w.r[1]);
               if (rsp_res_z !== w.r[2]) report_mismatch("res_z", rsp_res_z, w.r[2]);
               if (rsp_res_w !== w.r[3]) report_mismatch("res_w", rsp_res_w, w.r[3]);
               if (rsp_saturated !== w.sat)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(w.sat));
            end
         end
      end
   end
endmodule

/* tb/sv/matrix4_arith_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix4_arith_engine_tb
// Drives directed and random operations into the matrix engine under several
// idling patterns; the checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module matrix4_arith_engine_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_func;
   logic [3:0]  req_elem_index;
   logic signed [31:0] req_elem_value, req_scale;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z, req_vec_w;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [31:0] rsp_read_value, rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_w;
   logic        rsp_saturated;
   int          fail_count;
   int          pending;

   // idle percentages, changed per phase
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;   // forced receiver hold-off, counted below

   matrix4_arith_engine dut (.*);
   matrix4_arith_engine_chk checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stall, or long hold-off while the sender keeps offering
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Pick a value biased toward extremes and corner values
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh00010000;          // 1.0
         3: return 32'shffff0000;          // -1.0
         4: return $signed(32'($urandom_range(32'h3ffff))) - 32'sh20000;
         5: return 32'sh0;
         default: return $signed($urandom());
      endcase
   endfunction

   // Send one word: hold valid with a stable payload until accepted.
   // Valid drops only while idling, so back-to-back words keep it high.
   task automatic send_word(logic [3:0] fn, logic [3:0] idx, logic signed [31:0] ev,
                            logic signed [31:0] sc, logic signed [31:0] vx,
                            logic signed [31:0] vy, logic signed [31:0] vz,
                            logic signed [31:0] vw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= fn;
      req_elem_index <= idx;
      req_elem_value <= ev;
      req_scale      <= sc;
      req_vec_x      <= vx;
      req_vec_y      <= vy;
      req_vec_z      <= vz;
      req_vec_w      <= vw;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random();
      logic [3:0] fn;
      int r;
      r = $urandom_range(99);
      // mostly element traffic; arithmetic ops and unused codes share the rest
      if (r < 30) fn = mae_pkg::FN_WR_A;
      else if (r < 50) fn = mae_pkg::FN_WR_B;
      else if (r < 62) fn = mae_pkg::FN_RD_A;
      else if (r < 96) fn = 4'($urandom_range(mae_pkg::FN_ADD, mae_pkg::FN_MATVEC));
      else fn = 4'($urandom_range(mae_pkg::FN_UNUSED_LO, mae_pkg::FN_UNUSED_HI));
      send_word(fn, 4'($urandom()), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = mae_pkg::FN_WR_A;
      req_elem_index = '0;
      req_elem_value = '0;
      req_scale      = '0;
      req_vec_x      = '0;
      req_vec_y      = '0;
      req_vec_z      = '0;
      req_vec_w      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: read after reset, extremes, each op, saturation, unused codes
      send_word(mae_pkg::FN_RD_A, 4'd15, 0, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_WR_A, 4'd0, 32'sh7fffffff, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_WR_A, 4'd5, 32'sh80000000, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_WR_A, 4'd15, 32'sh00010000, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_WR_B, 4'd0, 32'sh7fffffff, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_WR_B, 4'd15, 32'sh80000000, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_RD_A, 4'd0, 0, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_ADD, 4'd0, 0, 0, 0, 0, 0, 0);          // clamps high
      send_word(mae_pkg::FN_SUB, 4'd0, 0, 0, 0, 0, 0, 0);          // no clamp: A[0] - B[0] is zero
      send_word(mae_pkg::FN_SCALE, 4'd0, 0, 32'sh80000000, 0, 0, 0, 0);
      send_word(mae_pkg::FN_ADD_SCL, 4'd0, 0, 32'sh7fffffff, 0, 0, 0, 0);
      send_word(mae_pkg::FN_VECMAT, 4'd0, 0, 0, 32'sh7fffffff, 32'sh80000000,
                32'sh10000, -1);
      send_word(mae_pkg::FN_MATVEC, 4'd0, 0, 0, 32'sh80000000, 32'sh7fffffff,
                -1, 32'sh10000);
      send_word(mae_pkg::FN_MATMUL, 4'd0, 0, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_RD_A, 4'd5, 0, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_UNUSED_HI, 4'd15, -1, -1, -1, -1, -1, -1);
      send_word(mae_pkg::FN_UNUSED_LO, 4'd3, 0, 0, 0, 0, 0, 0);
      send_word(mae_pkg::FN_SCALE, 4'd0, 0, 32'sh0, 0, 0, 0, 0);   // A cleared by zero scale
      send_word(mae_pkg::FN_VECMAT, 4'd0, 0, 0, -1, -1, -1, -1);

      // pressure: receiver holds off long while sender keeps offering
      hold_off_cycles = 400;
      for (int n = 0; n < 25; n++) send_random();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (int n = 0; n < 330; n++) send_random();
      end
      req_valid <= 1'b0;

      recv_stall_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* matrix4_arith_engine.f */
hw/rtl/mae_pkg.sv
hw/rtl/matrix4_arith_engine.sv
hw/rtl/mae_checker.sv
tb/sv/matrix4_arith_engine_chk.sv
tb/sv/matrix4_arith_engine_tb.sv
